FILE: sv/assert_macros.svh
// Assertion helpers; clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/lav_pkg.sv
`timescale 1ns / 1ps
package lav_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W = 32;
  // the largest normalized magnitude lies in [2^30, 2^31)
  localparam int NORM_W = 31;
  // one result bit of the 64-bit square root per stage
  localparam int SQRT_STEPS = 32;
endpackage

FILE: sv/lav_norm3.sv
`timescale 1ns / 1ps
module lav_norm3 #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int IN_W = 33,
  parameter int SIDE_W = 96
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [IN_W-1:0]      in_x,
  input  logic signed [IN_W-1:0]      in_y,
  input  logic signed [IN_W-1:0]      in_z,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_x,
  output logic signed [FRAC_BITS+1:0] out_y,
  output logic signed [FRAC_BITS+1:0] out_z,
  output logic [SIDE_W-1:0]           out_side
);
  import lav_pkg::*;

  localparam int MW  = IN_W;
  localparam int SW  = $clog2(MW + 1);
  localparam int QW  = FRAC_BITS + 1;
  localparam int UW  = FRAC_BITS + 2;
  localparam int NW  = FRAC_BITS + 32;
  localparam int MT  = SIDE_W + 4;
  localparam int LAT = 7 + SQRT_STEPS + QW;

  logic signed [IN_W-1:0] vin [3];
  logic [LAT-1:0]         vld;
  logic [MT-1:0]          meta [LAT];

  logic [MW-1:0]          mag0 [3];
  logic [MW-1:0]          mag1 [3];
  logic [MW-1:0]          orv;
  logic [SW-1:0]          lead;
  logic [SW-1:0]          sh1;
  logic [MW+NORM_W-1:0]   wide [3];
  logic [NORM_W-1:0]      nm2 [3];
  logic [NORM_W-1:0]      nm3 [3];
  logic [NORM_W-1:0]      nm4 [3];
  logic [2*NORM_W-1:0]    sq3 [3];
  logic [63:0]            sum4;
  logic [63:0]            rad [SQRT_STEPS];
  logic [63:0]            root [SQRT_STEPS];
  logic [NORM_W-1:0]      nmd [SQRT_STEPS][3];
  logic [NW-1:0]          num [3];
  logic [31:0]            dlen;
  logic [NW-1:0]          rem [QW][3];
  logic [QW-1:0]          quo [QW][3];
  logic [31:0]            dvs [QW];
  logic signed [UW-1:0]   outu [3];

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  // meta: side data, sign of x, y, z, zero-vector flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[0] <= {in_side, in_x[IN_W-1], in_y[IN_W-1], in_z[IN_W-1],
                   (in_x == '0) && (in_y == '0) && (in_z == '0)};
      for (int k = 1; k < LAT; k++) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  // magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag0[i] <= vin[i][IN_W-1] ? MW'(-vin[i]) : MW'(vin[i]);
      end
    end
  end

  // leading one of the largest magnitude equals that of the OR
  always_comb begin
    orv = mag0[0] | mag0[1] | mag0[2];
    lead = '0;
    for (int b = 0; b < MW; b++) begin
      if (orv[b]) begin
        lead = SW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh1 <= lead;
      mag1 <= mag0;
    end
  end

  // scale so the top bit lands on bit 30, truncating
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mag1[i], NORM_W'(0)} >> sh1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nm2[i] <= wide[i][NORM_W-1:0];
        sq3[i] <= nm2[i] * nm2[i];
      end
      nm3 <= nm2;
      nm4 <= nm3;
      sum4 <= 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]);
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0]       rin;
    logic [63:0]       qin;
    logic [63:0]       trial;
    logic [NORM_W-1:0] nin [3];
    if (j == 0) begin : g_first
      assign rin = sum4;
      assign qin = '0;
      assign nin = nm4;
    end else begin : g_next
      assign rin = rad[j-1];
      assign qin = root[j-1];
      assign nin = nmd[j-1];
    end
    assign trial = qin + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rad[j] <= rin - trial;
          root[j] <= (qin >> 1) + BIT;
        end else begin
          rad[j] <= rin;
          root[j] <= qin >> 1;
        end
        nmd[j] <= nin;
      end
    end
  end

  // rounded dividend
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= NW'({nmd[SQRT_STEPS-1][i], FRAC_BITS'(0)}) +
                  NW'(root[SQRT_STEPS-1][31:1]);
      end
      dlen <= root[SQRT_STEPS-1][31:0];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int POS = QW - 1 - s;
    logic [NW-1:0] rin [3];
    logic [QW-1:0] qin [3];
    logic [31:0]   din;
    logic [NW-1:0] dsh;
    if (s == 0) begin : g_first
      assign rin = num;
      assign qin = '{'0, '0, '0};
      assign din = dlen;
    end else begin : g_next
      assign rin = rem[s-1];
      assign qin = quo[s-1];
      assign din = dvs[s-1];
    end
    assign dsh = NW'(din) << POS;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rin[i] >= dsh) begin
            rem[s][i] <= rin[i] - dsh;
            quo[s][i] <= qin[i] | (QW'(1) << POS);
          end else begin
            rem[s][i] <= rin[i];
            quo[s][i] <= qin[i];
          end
        end
        dvs[s] <= din;
      end
    end
  end

  // restore sign, drop zero vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (meta[LAT-2][0]) begin
          outu[i] <= '0;
        end else if (meta[LAT-2][3-i]) begin
          outu[i] <= -$signed(UW'(quo[QW-1][i]));
        end else begin
          outu[i] <= $signed(UW'(quo[QW-1][i]));
        end
      end
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_x = outu[0];
  assign out_y = outu[1];
  assign out_z = outu[2];
  assign out_side = meta[LAT-1][MT-1:4];
endmodule

FILE: sv/look_at_view_matrix.sv
`timescale 1ns / 1ps
// Look-at view basis in signed fixed point (FRAC_BITS fraction bits, Q16.16
// by default). Each transfer on the request side carries an eye point and a
// target point; each transfer on the response side carries the unit back,
// right and up axes of a camera whose world up is (0,1,0), plus the three
// translation terms -dot(eye, axis), rounded half away from zero and
// saturated. A zero-length axis comes out as zero. The block takes one
// transfer per clock while req_stall is low. Its pipeline runs through the
// three normalizers in series, each running a 32-stage square root and a
// FRAC_BITS+1 stage divider. The result register lets a new request in
// while a finished response waits, as long as the stage in front of it is
// empty.
`include "assert_macros.svh"
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic signed [lav_pkg::WORD_W-1:0] eye_x,
  input  logic signed [lav_pkg::WORD_W-1:0] eye_y,
  input  logic signed [lav_pkg::WORD_W-1:0] eye_z,
  input  logic signed [lav_pkg::WORD_W-1:0] aim_x,
  input  logic signed [lav_pkg::WORD_W-1:0] aim_y,
  input  logic signed [lav_pkg::WORD_W-1:0] aim_z,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic signed [lav_pkg::WORD_W-1:0] right_x,
  output logic signed [lav_pkg::WORD_W-1:0] right_y,
  output logic signed [lav_pkg::WORD_W-1:0] right_z,
  output logic signed [lav_pkg::WORD_W-1:0] upward_x,
  output logic signed [lav_pkg::WORD_W-1:0] upward_y,
  output logic signed [lav_pkg::WORD_W-1:0] upward_z,
  output logic signed [lav_pkg::WORD_W-1:0] back_x,
  output logic signed [lav_pkg::WORD_W-1:0] back_y,
  output logic signed [lav_pkg::WORD_W-1:0] back_z,
  output logic signed [lav_pkg::WORD_W-1:0] shift_right,
  output logic signed [lav_pkg::WORD_W-1:0] shift_up,
  output logic signed [lav_pkg::WORD_W-1:0] shift_back
);
  import lav_pkg::*;

  localparam int UW    = FRAC_BITS + 2;        // unit component, |u| <= 2^F
  localparam int XW    = 2 * UW;               // cross product term
  localparam int DW    = WORD_W + UW;          // eye times axis
  localparam int NDW   = DW + 3;               // negated sum of three
  localparam int EYE_W = 3 * WORD_W;
  localparam int AX_W  = 3 * UW;
  localparam logic signed [WORD_W-1:0] UNIT = WORD_W'(1) << FRAC_BITS;

  // Pipeline advances unless the result register is full and stalled,
  // but a bubble in the last stage may still be squeezed out.
  logic adv;
  logic oe;
  logic d2_valid;

  assign oe = !(rsp_valid && rsp_stall);
  assign adv = oe || !d2_valid;
  assign req_stall = !adv;

  // eye minus target, one bit wider
  logic                    a_valid;
  logic signed [32:0]      d_x, d_y, d_z;
  logic [EYE_W-1:0]        a_eye;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_x <= 33'(eye_x) - 33'(aim_x);
      d_y <= 33'(eye_y) - 33'(aim_y);
      d_z <= 33'(eye_z) - 33'(aim_z);
      a_eye <= {eye_x, eye_y, eye_z};
    end
  end

  // back = normalize(eye - aim)
  logic                 b_valid;
  logic signed [UW-1:0] bk_x, bk_y, bk_z;
  logic [EYE_W-1:0]     b_eye;

  lav_norm3 #(
    .FRAC_BITS(FRAC_BITS),
    .IN_W(33),
    .SIDE_W(EYE_W)
  ) u_norm_back (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(a_valid),
    .in_x(d_x),
    .in_y(d_y),
    .in_z(d_z),
    .in_side(a_eye),
    .out_valid(b_valid),
    .out_x(bk_x),
    .out_y(bk_y),
    .out_z(bk_z),
    .out_side(b_eye)
  );

  // right = normalize(up x back) = normalize(bk_z, 0, -bk_x)
  logic                    r_valid;
  logic signed [UW-1:0]    rt_x, rt_y, rt_z;
  logic [EYE_W+AX_W-1:0]   r_side;
  logic signed [UW-1:0]    neg_bk_x;

  assign neg_bk_x = -bk_x;

  lav_norm3 #(
    .FRAC_BITS(FRAC_BITS),
    .IN_W(UW),
    .SIDE_W(EYE_W + AX_W)
  ) u_norm_right (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(b_valid),
    .in_x(bk_z),
    .in_y('0),
    .in_z(neg_bk_x),
    .in_side({b_eye, bk_x, bk_y, bk_z}),
    .out_valid(r_valid),
    .out_x(rt_x),
    .out_y(rt_y),
    .out_z(rt_z),
    .out_side(r_side)
  );

  // back x right: products, then differences
  logic signed [UW-1:0]      rb_x, rb_y, rb_z;
  logic                      c1_valid, c2_valid;
  logic signed [XW-1:0]      pc [6];
  logic signed [XW-1:0]      t_x, t_y, t_z;
  logic [EYE_W+2*AX_W-1:0]   c1_side, c2_side;

  assign rb_x = r_side[AX_W-1 -: UW];
  assign rb_y = r_side[AX_W-UW-1 -: UW];
  assign rb_z = r_side[UW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
    end else if (adv) begin
      c1_valid <= r_valid;
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc[0] <= rb_y * rt_z;
      pc[1] <= rb_z * rt_y;
      pc[2] <= rb_z * rt_x;
      pc[3] <= rb_x * rt_z;
      pc[4] <= rb_x * rt_y;
      pc[5] <= rb_y * rt_x;
      c1_side <= {r_side, rt_x, rt_y, rt_z};
      t_x <= pc[0] - pc[1];
      t_y <= pc[2] - pc[3];
      t_z <= pc[4] - pc[5];
      c2_side <= c1_side;
    end
  end

  // upward = normalize(back x right)
  logic                      u_valid;
  logic signed [UW-1:0]      up_x, up_y, up_z;
  logic [EYE_W+2*AX_W-1:0]   u_side;

  lav_norm3 #(
    .FRAC_BITS(FRAC_BITS),
    .IN_W(XW),
    .SIDE_W(EYE_W + 2 * AX_W)
  ) u_norm_up (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(c2_valid),
    .in_x(t_x),
    .in_y(t_y),
    .in_z(t_z),
    .in_side(c2_side),
    .out_valid(u_valid),
    .out_x(up_x),
    .out_y(up_y),
    .out_z(up_z),
    .out_side(u_side)
  );

  // Translation: exact dot products with 2*FRAC_BITS fraction bits.
  // Axis order in the packed vectors: back, right, up.
  logic signed [WORD_W-1:0] eyev [3];
  logic signed [UW-1:0]     axu [9];
  logic [3*AX_W-1:0]        u_axes;
  logic                     d1_valid;
  logic signed [DW-1:0]     pr [9];
  logic [3*AX_W-1:0]        d1_axes, d2_axes;
  logic signed [NDW-1:0]    nd [3];
  logic signed [UW-1:0]     axv [9];
  logic signed [WORD_W-1:0] shv [3];

  assign u_axes = {u_side[2*AX_W-1:0], up_x, up_y, up_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eyev[i] = u_side[EYE_W+2*AX_W-1-i*WORD_W -: WORD_W];
    end
    for (int k = 0; k < 9; k++) begin
      axu[k] = u_axes[(8-k)*UW +: UW];
      axv[k] = d2_axes[(8-k)*UW +: UW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
    end else if (adv) begin
      d1_valid <= u_valid;
      d2_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pr[i] <= eyev[i] * axu[3+i];
        pr[3+i] <= eyev[i] * axu[6+i];
        pr[6+i] <= eyev[i] * axu[i];
      end
      d1_axes <= u_axes;
      for (int j = 0; j < 3; j++) begin
        nd[j] <= -(NDW'(pr[3*j]) + NDW'(pr[3*j+1]) + NDW'(pr[3*j+2]));
      end
      d2_axes <= d1_axes;
    end
  end

  // Round half away from zero to FRAC_BITS, then saturate to 32 bits.
  function automatic logic signed [WORD_W-1:0] round_sat(
    input logic signed [NDW-1:0] n
  );
    logic [NDW-1:0] m;
    logic [NDW-1:0] r;
    logic signed [WORD_W-1:0] res;
    m = n[NDW-1] ? NDW'(-n) : NDW'(n);
    r = (m + (NDW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (n[NDW-1]) begin
      if (r > NDW'(33'h1_0000_0000 >> 1)) begin
        res = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
        res = -$signed(WORD_W'(r));
      end
    end else begin
      if (r > NDW'({(WORD_W-1){1'b1}})) begin
        res = {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
        res = $signed(WORD_W'(r));
      end
    end
    return res;
  endfunction

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shv[j] = round_sat(nd[j]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (oe) begin
      rsp_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (oe) begin
      back_x <= WORD_W'(axv[0]);
      back_y <= WORD_W'(axv[1]);
      back_z <= WORD_W'(axv[2]);
      right_x <= WORD_W'(axv[3]);
      right_y <= WORD_W'(axv[4]);
      right_z <= WORD_W'(axv[5]);
      upward_x <= WORD_W'(axv[6]);
      upward_y <= WORD_W'(axv[7]);
      upward_z <= WORD_W'(axv[8]);
      shift_right <= shv[0];
      shift_up <= shv[1];
      shift_back <= shv[2];
    end
  end

  // eye on the target: everything collapses to zero
  logic back_zero;
  logic rest_zero;

  assign back_zero = (back_x == '0) && (back_y == '0) && (back_z == '0);
  assign rest_zero = (right_x == '0) && (right_z == '0) && (upward_y == '0) &&
                     (shift_back == '0) && (shift_right == '0);

  // right axis always lies in the horizontal plane
  `ASSERT_IMP(a_right_flat, rsp_valid, right_y == '0)
  `ASSERT_IMP(a_back_unit, rsp_valid, (back_x <= UNIT) && (back_x >= -UNIT))
  `ASSERT_IMP(a_zero_basis, rsp_valid && back_zero, rest_zero)
  // a taken response with nothing behind it leaves the register empty
  `ASSERT_NEXT(a_drain, rsp_valid && !rsp_stall && !d2_valid, !rsp_valid)
endmodule

FILE: tb/tb_look_at_view_matrix.sv
`timescale 1ns / 1ps
module tb_look_at_view_matrix;
  import lav_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 6 + 3 * (40 + FB);
  localparam int N_RANDOM = 1130;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t ex, ey, ez, ax, ay, az;
  } pose_t;

  typedef struct packed {
    word_t rx, ry, rz, ux, uy, uz, bx, by, bz, sr, su, sb;
  } basis_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  word_t eye_x = 0, eye_y = 0, eye_z = 0, aim_x = 0, aim_y = 0, aim_z = 0;
  logic rsp_valid;
  logic rsp_stall = 0;
  word_t right_x, right_y, right_z, upward_x, upward_y, upward_z;
  word_t back_x, back_y, back_z, shift_right, shift_up, shift_back;

  look_at_view_matrix dut (.*);

  always #10 clk = ~clk;

  pose_t pose_q[$];      // poses waiting to be driven
  basis_t basis_q[$];    // predicted view bases, oldest first
  int errors = 0;
  int send_idle = 0;     // idle percentage for the request side
  int recv_idle = 0;     // stall percentage for the response side
  int n_sent = 0, n_seen = 0;

  // Integer square root, floor, of a 64-bit value.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale a vector to unit length in fixed point; zero stays zero.
  function automatic void to_unit(input longint v[3], output longint u[3]);
    longint unsigned m[3], top, sum, len, q;
    int p;
    top = 0;
    sum = 0;
    p = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return;
    end
    while (p < 63 && (top >> (p + 1)) != 0) p++;
    for (int i = 0; i < 3; i++) begin
      if (p > 30) m[i] >>= (p - 30);
      else m[i] <<= (30 - p);
      sum += m[i] * m[i];
    end
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // Negated dot product, rounded half away from zero and saturated.
  function automatic word_t neg_proj(longint e[3], longint a[3]);
    longint s;
    longint unsigned r, mg;
    s = -(e[0] * a[0] + e[1] * a[1] + e[2] * a[2]);
    mg = s < 0 ? -s : s;
    r = (mg + (64'd1 << (FB - 1))) >> FB;
    if (s < 0) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      return word_t'(-longint'(r));
    end
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    return word_t'(r);
  endfunction

  function automatic basis_t view_basis(pose_t p);
    longint eye[3], d[3], bk[3], rt[3], up[3], t[3];
    basis_t b;
    eye[0] = p.ex; eye[1] = p.ey; eye[2] = p.ez;
    d[0] = eye[0] - longint'(p.ax);
    d[1] = eye[1] - longint'(p.ay);
    d[2] = eye[2] - longint'(p.az);
    to_unit(d, bk);
    // world up crossed with back
    t[0] = bk[2]; t[1] = 0; t[2] = -bk[0];
    to_unit(t, rt);
    t[0] = bk[1] * rt[2] - bk[2] * rt[1];
    t[1] = bk[2] * rt[0] - bk[0] * rt[2];
    t[2] = bk[0] * rt[1] - bk[1] * rt[0];
    to_unit(t, up);
    b.rx = rt[0]; b.ry = rt[1]; b.rz = rt[2];
    b.ux = up[0]; b.uy = up[1]; b.uz = up[2];
    b.bx = bk[0]; b.by = bk[1]; b.bz = bk[2];
    b.sr = neg_proj(eye, rt);
    b.su = neg_proj(eye, up);
    b.sb = neg_proj(eye, bk);
    return b;
  endfunction

  function automatic word_t any_word();
    // mix small, extreme and full-range values
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 8)) - 4 <<< FB;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return word_t'($signed($urandom_range(0, 65535)) - 32768);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic pose_t make_pose(word_t ex, ey, ez, ax, ay, az);
    pose_t p;
    p.ex = ex; p.ey = ey; p.ez = ez; p.ax = ax; p.ay = ay; p.az = az;
    return p;
  endfunction

  // Driver: advance to the next pose after each transfer, hold while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) n_sent <= n_sent + 1;
      if (!req_valid || !req_stall) begin
        if (pose_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          pose_t p;
          p = pose_q.pop_front();
          basis_q.push_back(view_basis(p));
          req_valid <= 1;
          eye_x <= p.ex; eye_y <= p.ey; eye_z <= p.ez;
          aim_x <= p.ax; aim_y <= p.ay; aim_z <= p.az;
        end else begin
          req_valid <= 0;
        end
      end
      rsp_stall <= $urandom_range(0, 99) < recv_idle;
    end
  end

  // Monitor: compare each response transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      n_seen <= n_seen + 1;
      if (basis_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        basis_t e;
        e = basis_q.pop_front();
        if (right_x !== e.rx) begin $error("right_x exp %0d got %0d", e.rx, right_x); errors++; end
        if (right_y !== e.ry) begin $error("right_y exp %0d got %0d", e.ry, right_y); errors++; end
        if (right_z !== e.rz) begin $error("right_z exp %0d got %0d", e.rz, right_z); errors++; end
        if (upward_x !== e.ux) begin $error("upward_x exp %0d got %0d", e.ux, upward_x); errors++; end
        if (upward_y !== e.uy) begin $error("upward_y exp %0d got %0d", e.uy, upward_y); errors++; end
        if (upward_z !== e.uz) begin $error("upward_z exp %0d got %0d", e.uz, upward_z); errors++; end
        if (back_x !== e.bx) begin $error("back_x exp %0d got %0d", e.bx, back_x); errors++; end
        if (back_y !== e.by) begin $error("back_y exp %0d got %0d", e.by, back_y); errors++; end
        if (back_z !== e.bz) begin $error("back_z exp %0d got %0d", e.bz, back_z); errors++; end
        if (shift_right !== e.sr) begin
          $error("shift_right exp %0d got %0d", e.sr, shift_right); errors++;
        end
        if (shift_up !== e.su) begin
          $error("shift_up exp %0d got %0d", e.su, shift_up); errors++;
        end
        if (shift_back !== e.sb) begin
          $error("shift_back exp %0d got %0d", e.sb, shift_back); errors++;
        end
      end
    end
  end

  // Drain: wait until the queue of pending poses is empty and nothing is in flight.
  task automatic drain();
    while (pose_q.size() > 0 || req_valid || basis_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    word_t one, mx, mn;
    one = 32'sd1 <<< FB;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed poses: eye on aim, eye straight above and below, the axis
    // directions, extreme corners and translations that saturate.
    pose_q.push_back(make_pose(0, 0, 0, 0, 0, 0));
    pose_q.push_back(make_pose(mx, mx, mx, mx, mx, mx));
    pose_q.push_back(make_pose(0, one, 0, 0, 0, 0));
    pose_q.push_back(make_pose(0, -one, 0, 0, 0, 0));
    pose_q.push_back(make_pose(5 * one, mx, -3 * one, 5 * one, mn, -3 * one));
    pose_q.push_back(make_pose(one, 0, 0, 0, 0, 0));
    pose_q.push_back(make_pose(-one, 0, 0, 0, 0, 0));
    pose_q.push_back(make_pose(0, 0, one, 0, 0, 0));
    pose_q.push_back(make_pose(0, 0, -one, 0, 0, 0));
    pose_q.push_back(make_pose(0, 0, 10 * one, 0, 0, 0));
    pose_q.push_back(make_pose(mx, mx, mx, mn, mn, mn));
    pose_q.push_back(make_pose(mn, mn, mn, mx, mx, mx));
    pose_q.push_back(make_pose(mx, mn, mx, mn, mx, mn));
    pose_q.push_back(make_pose(mn, 0, mx, 0, 0, 0));
    pose_q.push_back(make_pose(1, 0, 0, 0, 0, 0));
    pose_q.push_back(make_pose(1, 1, 1, 0, 0, 0));
    pose_q.push_back(make_pose(-1, -1, -1, 0, 0, 0));
    pose_q.push_back(make_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    pose_q.push_back(make_pose(3 * one, 4 * one, 0, 0, 0, 0));

    // Random poses in three idle phases.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 15 : ph == 1 ? 79 : 0;
      recv_idle = ph == 0 ? 79 : ph == 1 ? 15 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        if ($urandom_range(0, 9) == 0)
          pose_q.push_back(make_pose(any_word(), any_word(), any_word(),
                                     any_word(), any_word(), any_word()));
        else begin
          word_t ex, ez;
          ex = any_word();
          ez = any_word();
          // occasionally share x and z so the eye sits above or below the aim
          if ($urandom_range(0, 19) == 0)
            pose_q.push_back(make_pose(ex, any_word(), ez, ex, any_word(), ez));
          else
            pose_q.push_back(make_pose(ex, any_word(), ez,
                                       any_word(), any_word(), any_word()));
        end
      end
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d poses, checked %0d view bases across three idle/stall mixes.",
             n_sent, n_seen);
    if (errors == 0 && basis_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #(20ns * 400000);
    $display("TB_ERROR");
    $finish;
  end
endmodule
